// File: sv/at2d_pkg.sv
package at2d_pkg;

    typedef logic signed [31:0] val_t;
    typedef logic signed [15:0] ang_t;

    localparam int XW           = 34;
    localparam int ZW           = 26;
    localparam int SATW         = 72;
    localparam int CORDIC_STEPS = 22;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int SHEAR_LIMIT  = 22784;
    localparam int ROT_FULL     = 23040;
    localparam int ROT_Q90      = 5760;
    localparam int ROT_Q180     = 11520;
    localparam int ROT_Q270     = 17280;

    localparam logic [63:0] POS_LIM64 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_LIM64 = 64'h0000_0000_8000_0000;

    localparam logic signed [SATW-1:0] SAT_HI = 72'sh7FFF_FFFF;
    localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - 72'sd1;

    typedef struct packed {
        val_t pos_x;
        val_t pos_y;
        val_t size_w;
        val_t size_h;
        val_t pivot_x;
        val_t pivot_y;
    } carry_t;

    typedef struct packed {
        val_t m11;
        val_t m12;
        val_t m21;
        val_t m22;
    } mat_t;

    typedef struct packed {
        mat_t m;
        val_t tx;
        val_t ty;
    } fwd_t;

    // arctangent of 2^-i in degrees, 16 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
        case (i)
            0:       return ZW'(2949120);
            1:       return ZW'(1740967);
            2:       return ZW'(919879);
            3:       return ZW'(466945);
            4:       return ZW'(234379);
            5:       return ZW'(117304);
            6:       return ZW'(58666);
            7:       return ZW'(29335);
            8:       return ZW'(14668);
            9:       return ZW'(7334);
            10:      return ZW'(3667);
            11:      return ZW'(1833);
            12:      return ZW'(917);
            13:      return ZW'(458);
            14:      return ZW'(229);
            15:      return ZW'(115);
            16:      return ZW'(57);
            17:      return ZW'(29);
            18:      return ZW'(14);
            19:      return ZW'(7);
            20:      return ZW'(4);
            21:      return ZW'(2);
            default: return '0;
        endcase
    endfunction

    function automatic val_t sat32(input logic signed [SATW-1:0] v);
        if (v > SAT_HI)
            return val_t'(SAT_HI[31:0]);
        if (v < SAT_LO)
            return val_t'(SAT_LO[31:0]);
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input val_t v);
        logic signed [32:0] e;
        e = 33'(v);
        return e[32] ? 32'(-e) : 32'(e);
    endfunction

endpackage

// File: sv/at2d_div.sv
module at2d_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg,
    output at2d_pkg::val_t   q
);
    import at2d_pkg::*;

    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(POS_LIM64);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(NEG_LIM64);

    logic [DEN_W-1:0] rem_w [0:NUM_W];
    logic [NUM_W-1:0] nq_w  [0:NUM_W];
    logic [DEN_W-1:0] den_w [0:NUM_W];
    logic             neg_w [0:NUM_W];

    logic [DEN_W-1:0] rem_reg [1:NUM_W];
    logic [NUM_W-1:0] nq_reg  [1:NUM_W];
    logic [DEN_W-1:0] den_reg [1:NUM_W];
    logic             neg_reg [1:NUM_W];

    val_t q_next;
    val_t q_reg;

    assign rem_w[0] = '0;
    assign nq_w[0]  = num;
    assign den_w[0] = den;
    assign neg_w[0] = neg;

    // one quotient bit per stage; the numerator shifts out the top as quotient bits enter
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_w[k], nq_w[k][NUM_W-1]};
        assign diff  = trial - {1'b0, den_w[k]};
        assign ge    = trial >= {1'b0, den_w[k]};

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_reg[k+1]  <= {nq_w[k][NUM_W-2:0], ge};
            den_reg[k+1] <= den_w[k];
            neg_reg[k+1] <= neg_w[k];
        end

        assign rem_w[k+1] = rem_reg[k+1];
        assign nq_w[k+1]  = nq_reg[k+1];
        assign den_w[k+1] = den_reg[k+1];
        assign neg_w[k+1] = neg_reg[k+1];
    end

    // apply sign and saturate
    always_comb
    begin
        if (!neg_w[NUM_W])
        begin
            if (nq_w[NUM_W] > POS_LIM)
                q_next = val_t'(POS_LIM64[31:0]);
            else
                q_next = nq_w[NUM_W][31:0];
        end
        else
        begin
            if (nq_w[NUM_W] > NEG_LIM)
                q_next = val_t'(NEG_LIM64[31:0]);
            else
                q_next = ~nq_w[NUM_W][31:0] + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: sv/affine_2d_transform_setup.sv
// Throughput: one word per cycle; busy is always low and the pipeline never stalls.
// Depth is set by the 22-step CORDIC, the tangent divider (one bit per stage) and
// the inverse divider (one bit per stage); everything else is multiply/round stages.
// Reset clears the valid pipeline only; words in flight are dropped.
// The receiver cannot stall: each result shows for the one cycle that done is high.
module affine_2d_transform_setup #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  at2d_pkg::val_t  pos_x,
    input  at2d_pkg::val_t  pos_y,
    input  at2d_pkg::val_t  size_w,
    input  at2d_pkg::val_t  size_h,
    input  at2d_pkg::val_t  pivot_x,
    input  at2d_pkg::val_t  pivot_y,
    input  at2d_pkg::ang_t  shear_x_deg,
    input  at2d_pkg::ang_t  shear_y_deg,
    input  at2d_pkg::ang_t  rot_deg,
    output logic            done,
    output at2d_pkg::val_t  fwd_m11,
    output at2d_pkg::val_t  fwd_m12,
    output at2d_pkg::val_t  fwd_m21,
    output at2d_pkg::val_t  fwd_m22,
    output at2d_pkg::val_t  fwd_tx,
    output at2d_pkg::val_t  fwd_ty,
    output at2d_pkg::val_t  inv_m11,
    output at2d_pkg::val_t  inv_m12,
    output at2d_pkg::val_t  inv_m21,
    output at2d_pkg::val_t  inv_m22,
    output at2d_pkg::val_t  inv_tx,
    output at2d_pkg::val_t  inv_ty
);
    import at2d_pkg::*;

    // divider widths: tangent numerator |sin| << F, inverse numerator |cofactor| << F
    localparam int NUM_W1 = 33 + FRAC_BITS;
    localparam int DEN_W1 = 33;
    localparam int NUM_W2 = 32 + FRAC_BITS;
    localparam int DETW   = 66 - FRAC_BITS;
    localparam int DEN_W2 = DETW - 1;

    // register stage index of each step, counted from the input register
    localparam int I_CS  = CORDIC_STEPS + 2;
    localparam int I_TAN = I_CS + NUM_W1 + 1;
    localparam int I_INV = I_TAN + 7 + NUM_W2 + 1;
    localparam int I_OUT = I_INV + 2;

    localparam logic signed [64:0] HALF_F  = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [67:0] HALF_30 = 68'sd1 <<< 29;

    logic accept;
    logic [I_OUT:0] vld_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // -------------------------------------------------------------------------
    // Valid bits travel alongside the data, one per register stage.
    // -------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[I_OUT-1:0], accept};
    end

    // -------------------------------------------------------------------------
    // Input register; position, size and pivot ride a delay line to where they
    // are consumed.
    // -------------------------------------------------------------------------
    carry_t carry_reg [0:I_TAN+5];
    ang_t   shx_reg;
    ang_t   shy_reg;
    ang_t   rot_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            carry_reg[0] <= '{pos_x, pos_y, size_w, size_h, pivot_x, pivot_y};
            shx_reg      <= shear_x_deg;
            shy_reg      <= shear_y_deg;
            rot_reg      <= rot_deg;
        end
    end

    for (genvar k = 1; k <= I_TAN + 5; k++) begin : g_carry
        always_ff @(posedge clk)
        begin
            carry_reg[k] <= carry_reg[k-1];
        end
    end

    // -------------------------------------------------------------------------
    // Angle setup: clamp shears, wrap rotation and fold it into +-90 degrees.
    // Lane 0 is shear X, lane 1 shear Y, lane 2 the rotation.
    // -------------------------------------------------------------------------
    ang_t                  shx_c;
    ang_t                  shy_c;
    logic signed [16:0]    rot_w1;
    logic signed [16:0]    rot_w2;
    logic signed [16:0]    rot_q;
    logic                  rot_neg;
    logic signed [ZW-1:0]  z_next [3];

    always_comb
    begin
        shx_c = shx_reg;
        if (shx_reg > 16'sd22784)
            shx_c = 16'(SHEAR_LIMIT);
        else if (shx_reg < -16'sd22784)
            shx_c = -16'(SHEAR_LIMIT);

        shy_c = shy_reg;
        if (shy_reg > 16'sd22784)
            shy_c = 16'(SHEAR_LIMIT);
        else if (shy_reg < -16'sd22784)
            shy_c = -16'(SHEAR_LIMIT);

        // wrap into one turn
        rot_w1 = 17'(rot_reg);
        if (rot_w1 < 0)
            rot_w1 = rot_w1 + 17'(ROT_FULL);
        rot_w2 = rot_w1;
        if (rot_w1 < 0)
            rot_w2 = rot_w1 + 17'(ROT_FULL);
        else if (rot_w1 >= 17'(ROT_FULL))
            rot_w2 = rot_w1 - 17'(ROT_FULL);

        // fold: fourth quadrant goes negative, middle half flips through 180
        rot_neg = 1'b0;
        if (rot_w2 > 17'(ROT_Q270))
            rot_q = rot_w2 - 17'(ROT_FULL);
        else if (rot_w2 > 17'(ROT_Q90))
        begin
            rot_q   = rot_w2 - 17'(ROT_Q180);
            rot_neg = 1'b1;
        end
        else
            rot_q = rot_w2;

        z_next[0] = ZW'(shx_c) <<< 8;
        z_next[1] = ZW'(shy_c) <<< 8;
        z_next[2] = ZW'(rot_q) <<< 10;
    end

    // -------------------------------------------------------------------------
    // Three CORDIC rotators, one micro-rotation per stage.
    // -------------------------------------------------------------------------
    logic signed [XW-1:0] cx_reg   [3][CORDIC_STEPS+1];
    logic signed [XW-1:0] cy_reg   [3][CORDIC_STEPS+1];
    logic signed [ZW-1:0] cz_reg   [3][CORDIC_STEPS+1];
    logic [2:0]           side_reg [0:CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= {rot_neg, shy_reg == 16'sd0, shx_reg == 16'sd0};
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        always_ff @(posedge clk)
        begin
            cx_reg[l][0] <= XW'(CORDIC_GAIN);
            cy_reg[l][0] <= '0;
            cz_reg[l][0] <= z_next[l];
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
            always_ff @(posedge clk)
            begin
                if (!cz_reg[l][i][ZW-1])
                begin
                    cx_reg[l][i+1] <= cx_reg[l][i] - (cy_reg[l][i] >>> i);
                    cy_reg[l][i+1] <= cy_reg[l][i] + (cx_reg[l][i] >>> i);
                    cz_reg[l][i+1] <= cz_reg[l][i] - atan_deg(i);
                end
                else
                begin
                    cx_reg[l][i+1] <= cx_reg[l][i] + (cy_reg[l][i] >>> i);
                    cy_reg[l][i+1] <= cy_reg[l][i] - (cx_reg[l][i] >>> i);
                    cz_reg[l][i+1] <= cz_reg[l][i] + atan_deg(i);
                end
            end
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // -------------------------------------------------------------------------
    // Divider setup for tan = sin << F / cos; unfold the rotation result.
    // -------------------------------------------------------------------------
    logic [DEN_W1-1:0]    smag_reg [2];
    logic [DEN_W1-1:0]    cden_reg [2];
    logic                 sneg_reg [2];
    logic [1:0]           tz_reg   [I_CS:I_TAN];
    logic signed [XW-1:0] co_reg   [I_CS:I_TAN+2];
    logic signed [XW-1:0] si_reg   [I_CS:I_TAN+2];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            smag_reg[l] <= cy_reg[l][CORDIC_STEPS][XW-1]
                         ? DEN_W1'(-cy_reg[l][CORDIC_STEPS])
                         : DEN_W1'(cy_reg[l][CORDIC_STEPS]);
            cden_reg[l] <= DEN_W1'(cx_reg[l][CORDIC_STEPS]);
            sneg_reg[l] <= cy_reg[l][CORDIC_STEPS][XW-1];
        end
        // zero factor for a zero shear or a non-positive cosine
        tz_reg[I_CS][0] <= side_reg[CORDIC_STEPS][0]
                         || cx_reg[0][CORDIC_STEPS][XW-1]
                         || cx_reg[0][CORDIC_STEPS] == '0;
        tz_reg[I_CS][1] <= side_reg[CORDIC_STEPS][1]
                         || cx_reg[1][CORDIC_STEPS][XW-1]
                         || cx_reg[1][CORDIC_STEPS] == '0;
        co_reg[I_CS] <= side_reg[CORDIC_STEPS][2] ? -cx_reg[2][CORDIC_STEPS]
                                                  : cx_reg[2][CORDIC_STEPS];
        si_reg[I_CS] <= side_reg[CORDIC_STEPS][2] ? -cy_reg[2][CORDIC_STEPS]
                                                  : cy_reg[2][CORDIC_STEPS];
    end

    for (genvar k = I_CS + 1; k <= I_TAN; k++) begin : g_tz
        always_ff @(posedge clk)
        begin
            tz_reg[k] <= tz_reg[k-1];
        end
    end

    for (genvar k = I_CS + 1; k <= I_TAN + 2; k++) begin : g_cs
        always_ff @(posedge clk)
        begin
            co_reg[k] <= co_reg[k-1];
            si_reg[k] <= si_reg[k-1];
        end
    end

    val_t tan_q [2];

    for (genvar l = 0; l < 2; l++) begin : g_tan
        at2d_div #(
            .NUM_W (NUM_W1),
            .DEN_W (DEN_W1)
        ) u_tan_div (
            .clk (clk),
            .num ({smag_reg[l], {FRAC_BITS{1'b0}}}),
            .den (cden_reg[l]),
            .neg (sneg_reg[l]),
            .q   (tan_q[l])
        );
    end

    // -------------------------------------------------------------------------
    // Sheared size terms: b = w * tan(shear_y), c0 = h * tan(shear_x).
    // -------------------------------------------------------------------------
    val_t                 tanx_e;
    val_t                 tany_e;
    logic signed [63:0]   pb_next;
    logic signed [63:0]   pc_next;
    logic signed [63:0]   pb_reg;
    logic signed [63:0]   pc_reg;
    logic signed [64:0]   rb;
    logic signed [64:0]   rc;
    val_t                 b_reg;
    val_t                 c0_reg;

    always_comb
    begin
        tanx_e  = tz_reg[I_TAN][0] ? '0 : tan_q[0];
        tany_e  = tz_reg[I_TAN][1] ? '0 : tan_q[1];
        pb_next = carry_reg[I_TAN].size_w * tany_e;
        pc_next = carry_reg[I_TAN].size_h * tanx_e;
        rb      = (65'(pb_reg) + HALF_F) >>> FRAC_BITS;
        rc      = (65'(pc_reg) + HALF_F) >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        pb_reg <= pb_next;
        pc_reg <= pc_next;
        b_reg  <= sat32(72'(rb));
        c0_reg <= sat32(72'(rc));
    end

    // -------------------------------------------------------------------------
    // Rotate: eight products, then sum and round each element once.
    // -------------------------------------------------------------------------
    logic signed [65:0] pwc_reg;
    logic signed [65:0] pbs_reg;
    logic signed [65:0] pws_reg;
    logic signed [65:0] pbc_reg;
    logic signed [65:0] pcc_reg;
    logic signed [65:0] phs_reg;
    logic signed [65:0] pcs_reg;
    logic signed [65:0] phc_reg;
    logic signed [67:0] s11;
    logic signed [67:0] s12;
    logic signed [67:0] s21;
    logic signed [67:0] s22;
    mat_t               m_reg [I_TAN+4:I_TAN+5];

    always_ff @(posedge clk)
    begin
        pwc_reg <= carry_reg[I_TAN+2].size_w * co_reg[I_TAN+2];
        pbs_reg <= b_reg * si_reg[I_TAN+2];
        pws_reg <= carry_reg[I_TAN+2].size_w * si_reg[I_TAN+2];
        pbc_reg <= b_reg * co_reg[I_TAN+2];
        pcc_reg <= c0_reg * co_reg[I_TAN+2];
        phs_reg <= carry_reg[I_TAN+2].size_h * si_reg[I_TAN+2];
        pcs_reg <= c0_reg * si_reg[I_TAN+2];
        phc_reg <= carry_reg[I_TAN+2].size_h * co_reg[I_TAN+2];
    end

    always_comb
    begin
        s11 = 68'(pwc_reg) - 68'(pbs_reg) + HALF_30;
        s12 = 68'(pws_reg) + 68'(pbc_reg) + HALF_30;
        s21 = 68'(pcc_reg) - 68'(phs_reg) + HALF_30;
        s22 = 68'(pcs_reg) + 68'(phc_reg) + HALF_30;
    end

    always_ff @(posedge clk)
    begin
        m_reg[I_TAN+4].m11 <= sat32(72'(s11 >>> 30));
        m_reg[I_TAN+4].m12 <= sat32(72'(s12 >>> 30));
        m_reg[I_TAN+4].m21 <= sat32(72'(s21 >>> 30));
        m_reg[I_TAN+4].m22 <= sat32(72'(s22 >>> 30));
        m_reg[I_TAN+5]     <= m_reg[I_TAN+4];
    end

    // -------------------------------------------------------------------------
    // Translation row and determinant.
    // -------------------------------------------------------------------------
    logic signed [63:0]     q11_reg;
    logic signed [63:0]     q21_reg;
    logic signed [63:0]     q12_reg;
    logic signed [63:0]     q22_reg;
    logic signed [63:0]     d1_reg;
    logic signed [63:0]     d2_reg;
    logic signed [64:0]     r11;
    logic signed [64:0]     r21;
    logic signed [64:0]     r12;
    logic signed [64:0]     r22;
    logic signed [64:0]     rd1;
    logic signed [64:0]     rd2;
    logic signed [SATW-1:0] tx_sum;
    logic signed [SATW-1:0] ty_sum;
    logic signed [SATW-1:0] det_sum;
    logic signed [DETW-1:0] det_reg;
    fwd_t                   fwd_reg [I_TAN+6:I_OUT-1];

    always_ff @(posedge clk)
    begin
        q11_reg <= carry_reg[I_TAN+4].pivot_x * m_reg[I_TAN+4].m11;
        q21_reg <= carry_reg[I_TAN+4].pivot_y * m_reg[I_TAN+4].m21;
        q12_reg <= carry_reg[I_TAN+4].pivot_x * m_reg[I_TAN+4].m12;
        q22_reg <= carry_reg[I_TAN+4].pivot_y * m_reg[I_TAN+4].m22;
        d1_reg  <= m_reg[I_TAN+4].m11 * m_reg[I_TAN+4].m22;
        d2_reg  <= m_reg[I_TAN+4].m12 * m_reg[I_TAN+4].m21;
    end

    always_comb
    begin
        r11     = (65'(q11_reg) + HALF_F) >>> FRAC_BITS;
        r21     = (65'(q21_reg) + HALF_F) >>> FRAC_BITS;
        r12     = (65'(q12_reg) + HALF_F) >>> FRAC_BITS;
        r22     = (65'(q22_reg) + HALF_F) >>> FRAC_BITS;
        rd1     = (65'(d1_reg) + HALF_F) >>> FRAC_BITS;
        rd2     = (65'(d2_reg) + HALF_F) >>> FRAC_BITS;
        tx_sum  = SATW'(carry_reg[I_TAN+5].pos_x) + SATW'(carry_reg[I_TAN+5].pivot_x)
                - SATW'(r11) - SATW'(r21);
        ty_sum  = SATW'(carry_reg[I_TAN+5].pos_y) + SATW'(carry_reg[I_TAN+5].pivot_y)
                - SATW'(r12) - SATW'(r22);
        det_sum = SATW'(rd1) - SATW'(rd2);
    end

    always_ff @(posedge clk)
    begin
        fwd_reg[I_TAN+6].m  <= m_reg[I_TAN+5];
        fwd_reg[I_TAN+6].tx <= sat32(tx_sum);
        fwd_reg[I_TAN+6].ty <= sat32(ty_sum);
        det_reg             <= det_sum[DETW-1:0];
    end

    for (genvar k = I_TAN + 7; k <= I_OUT - 1; k++) begin : g_fwd
        always_ff @(posedge clk)
        begin
            fwd_reg[k] <= fwd_reg[k-1];
        end
    end

    // -------------------------------------------------------------------------
    // Inverse 2x2: cofactor << F / det, magnitudes into four dividers.
    // -------------------------------------------------------------------------
    logic signed [DETW-1:0] det_negv;
    logic [DEN_W2-1:0]      dmag_reg;
    logic [31:0]            cmag_reg [4];
    logic                   cneg_reg [4];
    logic                   dz_reg   [I_TAN+7:I_OUT-1];
    mat_t                   m6;

    assign det_negv = -det_reg;
    assign m6       = fwd_reg[I_TAN+6].m;

    always_ff @(posedge clk)
    begin
        dmag_reg <= det_reg[DETW-1] ? det_negv[DEN_W2-1:0] : det_reg[DEN_W2-1:0];
        dz_reg[I_TAN+7] <= det_reg == '0;
        cmag_reg[0] <= mag32(m6.m22);
        cmag_reg[1] <= mag32(m6.m12);
        cmag_reg[2] <= mag32(m6.m21);
        cmag_reg[3] <= mag32(m6.m11);
        // a zero cofactor divides to zero whatever the sign
        cneg_reg[0] <= m6.m22[31] ^ det_reg[DETW-1];
        cneg_reg[1] <= !m6.m12[31] ^ det_reg[DETW-1];
        cneg_reg[2] <= !m6.m21[31] ^ det_reg[DETW-1];
        cneg_reg[3] <= m6.m11[31] ^ det_reg[DETW-1];
    end

    for (genvar k = I_TAN + 8; k <= I_OUT - 1; k++) begin : g_dz
        always_ff @(posedge clk)
        begin
            dz_reg[k] <= dz_reg[k-1];
        end
    end

    val_t iq [4];

    for (genvar j = 0; j < 4; j++) begin : g_inv
        at2d_div #(
            .NUM_W (NUM_W2),
            .DEN_W (DEN_W2)
        ) u_inv_div (
            .clk (clk),
            .num ({cmag_reg[j], {FRAC_BITS{1'b0}}}),
            .den (dmag_reg),
            .neg (cneg_reg[j]),
            .q   (iq[j])
        );
    end

    // -------------------------------------------------------------------------
    // Inverse translation and output register.
    // -------------------------------------------------------------------------
    logic signed [63:0]     pa_reg;
    logic signed [63:0]     pb2_reg;
    logic signed [63:0]     pc2_reg;
    logic signed [63:0]     pd_reg;
    val_t                   iq_reg [4];
    logic signed [64:0]     ra;
    logic signed [64:0]     rb2;
    logic signed [64:0]     rc2;
    logic signed [64:0]     rd;
    logic signed [SATW-1:0] itx_sum;
    logic signed [SATW-1:0] ity_sum;
    fwd_t                   fo;
    logic                   dz;

    always_ff @(posedge clk)
    begin
        pa_reg  <= fwd_reg[I_INV].tx * iq[0];
        pb2_reg <= fwd_reg[I_INV].ty * iq[2];
        pc2_reg <= fwd_reg[I_INV].tx * iq[1];
        pd_reg  <= fwd_reg[I_INV].ty * iq[3];
        for (int j = 0; j < 4; j++)
            iq_reg[j] <= iq[j];
    end

    assign fo = fwd_reg[I_OUT-1];
    assign dz = dz_reg[I_OUT-1];

    always_comb
    begin
        ra      = (65'(pa_reg) + HALF_F) >>> FRAC_BITS;
        rb2     = (65'(pb2_reg) + HALF_F) >>> FRAC_BITS;
        rc2     = (65'(pc2_reg) + HALF_F) >>> FRAC_BITS;
        rd      = (65'(pd_reg) + HALF_F) >>> FRAC_BITS;
        itx_sum = -(SATW'(ra) + SATW'(rb2));
        ity_sum = -(SATW'(rc2) + SATW'(rd));
    end

    val_t fwd_m11_reg;
    val_t fwd_m12_reg;
    val_t fwd_m21_reg;
    val_t fwd_m22_reg;
    val_t fwd_tx_reg;
    val_t fwd_ty_reg;
    val_t inv_m11_reg;
    val_t inv_m12_reg;
    val_t inv_m21_reg;
    val_t inv_m22_reg;
    val_t inv_tx_reg;
    val_t inv_ty_reg;

    always_ff @(posedge clk)
    begin
        fwd_m11_reg <= fo.m.m11;
        fwd_m12_reg <= fo.m.m12;
        fwd_m21_reg <= fo.m.m21;
        fwd_m22_reg <= fo.m.m22;
        fwd_tx_reg  <= fo.tx;
        fwd_ty_reg  <= fo.ty;
        // singular matrix: drop the whole inverse to zero
        inv_m11_reg <= dz ? '0 : iq_reg[0];
        inv_m12_reg <= dz ? '0 : iq_reg[1];
        inv_m21_reg <= dz ? '0 : iq_reg[2];
        inv_m22_reg <= dz ? '0 : iq_reg[3];
        inv_tx_reg  <= dz ? '0 : sat32(itx_sum);
        inv_ty_reg  <= dz ? '0 : sat32(ity_sum);
    end

    assign done    = vld_reg[I_OUT];
    assign fwd_m11 = fwd_m11_reg;
    assign fwd_m12 = fwd_m12_reg;
    assign fwd_m21 = fwd_m21_reg;
    assign fwd_m22 = fwd_m22_reg;
    assign fwd_tx  = fwd_tx_reg;
    assign fwd_ty  = fwd_ty_reg;
    assign inv_m11 = inv_m11_reg;
    assign inv_m12 = inv_m12_reg;
    assign inv_m21 = inv_m21_reg;
    assign inv_m22 = inv_m22_reg;
    assign inv_tx  = inv_tx_reg;
    assign inv_ty  = inv_ty_reg;

    // -------------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##I_OUT done)
        else $error("accepted word did not complete at the fixed latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, I_OUT + 1))
        else $error("done without a matching accepted word");

    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[I_OUT-1] && dz |=> done && inv_m11 == '0 && inv_m22 == '0
                                   && inv_tx == '0 && inv_ty == '0)
        else $error("singular matrix produced a nonzero inverse");

endmodule
